@@ hw/rtl/rtts_pkg.sv @@
// Types and constants shared by the per-station round-trip statistics table.
// No dependencies.
`default_nettype none

package rtts_pkg;

  localparam logic signed [63:0] RTT_CEIL  = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [63:0] RTT_FLOOR = 64'sh8000_0000_0000_0000;

  typedef enum logic [1:0] {
    STAT_UPDATED = 2'd0,
    STAT_NEW     = 2'd1,
    STAT_DROPPED = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    BS_IDLE,
    BS_SCAN,
    BS_UPD,
    BS_DROP
  } back_state_e;

  typedef struct packed {
    logic        [31:0] addr;
    logic signed [63:0] rtt;
    logic               reserved;
  } item_t;

  typedef struct packed {
    logic signed [63:0] last;
    logic signed [63:0] min;
    logic signed [63:0] max;
    logic        [31:0] count;
  } stats_t;

endpackage

`default_nettype wire

@@ hw/rtl/per_station_rtt_stats_table.sv @@
// Top level of the per-station round-trip statistics table.
// Depends on rtts_pkg, rtts_front, rtts_fifo and rtts_back.
//
//   channel | handshake              | payload
//   --------+------------------------+-------------------------------------------
//   in      | in_valid_i, in_ready_o | station_address_i, round_trip_ns_i
//   out     | out_valid_o,           | status_o, entry_index_o, last_rtt_o,
//           | out_ready_i            | min_rtt_o, max_rtt_o, sample_count_o,
//           |                        | entries_in_use_o
//
// In the back end an item is popped and, unless it is reserved, the scan
// reads the address RAM once per occupied entry, stopping at the first
// match; the entry is then updated or claimed, or the item is dropped. The
// front and a two-entry queue take items while the back end scans. Reset
// empties the table at once through the fill level; no clearing pass. A
// stalled output holds the back end.
`default_nettype none

module per_station_rtt_stats_table #(
  parameter int TABLE_ENTRIES = 128
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output      logic               in_ready_o,
  input  wire logic        [31:0] station_address_i,
  input  wire logic signed [63:0] round_trip_ns_i,
  output      logic               out_valid_o,
  input  wire logic               out_ready_i,
  output      logic        [1:0]  status_o,
  output      logic        [6:0]  entry_index_o,
  output      logic signed [63:0] last_rtt_o,
  output      logic signed [63:0] min_rtt_o,
  output      logic signed [63:0] max_rtt_o,
  output      logic        [31:0] sample_count_o,
  output      logic        [7:0]  entries_in_use_o
);

  localparam int QueueDepth = 2;

  logic              push_valid, push_ready, pop_valid, pop_ready;
  rtts_pkg::item_t   push_item, pop_item;
  rtts_pkg::status_e status;

  rtts_front u_front (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .station_address_i (station_address_i),
    .round_trip_ns_i   (round_trip_ns_i),
    .push_valid_o      (push_valid),
    .push_ready_i      (push_ready),
    .push_item_o       (push_item)
  );

  rtts_fifo #(.DEPTH(QueueDepth)) u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_item_i  (push_item),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_item_o   (pop_item)
  );

  rtts_back #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .q_valid_i        (pop_valid),
    .q_ready_o        (pop_ready),
    .q_item_i         (pop_item),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .status_o         (status),
    .entry_index_o    (entry_index_o),
    .last_rtt_o       (last_rtt_o),
    .min_rtt_o        (min_rtt_o),
    .max_rtt_o        (max_rtt_o),
    .sample_count_o   (sample_count_o),
    .entries_in_use_o (entries_in_use_o)
  );

  assign status_o = status;

endmodule

`default_nettype wire

@@ hw/rtl/rtts_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module rtts_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output      logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

@@ hw/rtl/rtts_fifo.sv @@
// Short queue of classified items between front and back.
// Depends on rtts_pkg.
`default_nettype none

module rtts_fifo #(
  parameter int DEPTH = 2
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_valid_i,
  output      logic           push_ready_o,
  input  wire rtts_pkg::item_t push_item_i,
  output      logic           pop_valid_o,
  input  wire logic           pop_ready_i,
  output      rtts_pkg::item_t pop_item_o
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  rtts_pkg::item_t mem_q [DEPTH];
  logic [PW-1:0]   wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]   count_q, count_d;
  logic            push, pop;

  assign push_ready_o = (count_q != CW'(DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign push         = push_valid_i & push_ready_o;
  assign pop          = pop_valid_o & pop_ready_i;
  assign pop_item_o   = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(DEPTH))
    else $error("queue count beyond depth");

  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !pop) |=> (count_q == $past(count_q) + 1'b1))
    else $error("queue count did not advance on push");

  a_count_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && !push) |=> (count_q == $past(count_q) - 1'b1))
    else $error("queue count did not drop on pop");

endmodule

`default_nettype wire

@@ hw/rtl/rtts_front.sv @@
// Input stage: take a transfer, mark reserved addresses, hand on to the queue.
// Depends on rtts_pkg.
`default_nettype none

module rtts_front (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output      logic               in_ready_o,
  input  wire logic        [31:0] station_address_i,
  input  wire logic signed [63:0] round_trip_ns_i,
  output      logic               push_valid_o,
  input  wire logic               push_ready_i,
  output      rtts_pkg::item_t    push_item_o
);

  logic            valid_q, valid_d;
  rtts_pkg::item_t item_q;
  logic            accept;

  assign in_ready_o   = !valid_q || push_ready_i;
  assign accept       = in_valid_i & in_ready_o;
  assign push_valid_o = valid_q;
  assign push_item_o  = item_q;
  assign valid_d      = accept || (valid_q && !push_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q.addr     <= station_address_i;
      item_q.rtt      <= round_trip_ns_i;
      item_q.reserved <= (station_address_i == 32'd0);
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/rtts_back.sv @@
// Table engine: scan stored addresses, claim or update an entry, form the result.
// Depends on rtts_pkg and rtts_ram.
`default_nettype none

module rtts_back #(
  parameter int TABLE_ENTRIES = 128
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                q_valid_i,
  output      logic                q_ready_o,
  input  wire rtts_pkg::item_t     q_item_i,
  output      logic                out_valid_o,
  input  wire logic                out_ready_i,
  output      rtts_pkg::status_e   status_o,
  output      logic        [6:0]   entry_index_o,
  output      logic signed [63:0]  last_rtt_o,
  output      logic signed [63:0]  min_rtt_o,
  output      logic signed [63:0]  max_rtt_o,
  output      logic        [31:0]  sample_count_o,
  output      logic        [7:0]   entries_in_use_o
);

  localparam int IW = $clog2(TABLE_ENTRIES);
  localparam int CW = $clog2(TABLE_ENTRIES + 1);
  localparam int SW = $bits(rtts_pkg::stats_t);

  rtts_pkg::back_state_e state_q, state_d;
  rtts_pkg::item_t       cur_q, cur_d;
  logic [CW-1:0]         fill_q, fill_d, rd_ptr_q, rd_ptr_d;
  logic [IW-1:0]         cmp_idx_q, cmp_idx_d, idx_q, idx_d;
  logic                  cmp_valid_q, cmp_valid_d, hit_q, hit_d;
  logic                  out_valid_q, out_valid_d, out_free;
  logic                  match, scan_end, table_full;

  rtts_pkg::status_e     status_q, status_d;
  logic [6:0]            index_q, index_d;
  rtts_pkg::stats_t      res_q, res_d;
  logic [7:0]            in_use_q, in_use_d;

  logic [31:0]           addr_rdata;
  logic                  addr_we;
  rtts_pkg::stats_t      stats_rdata, stats_base, stats_new;
  logic                  stats_we;
  logic [IW-1:0]         stats_raddr;

  rtts_ram #(.WIDTH(32), .DEPTH(TABLE_ENTRIES)) u_addr_ram (
    .clk_i   (clk_i),
    .we_i    (addr_we),
    .waddr_i (fill_q[IW-1:0]),
    .wdata_i (cur_q.addr),
    .raddr_i (rd_ptr_q[IW-1:0]),
    .rdata_o (addr_rdata)
  );

  rtts_ram #(.WIDTH(SW), .DEPTH(TABLE_ENTRIES)) u_stats_ram (
    .clk_i   (clk_i),
    .we_i    (stats_we),
    .waddr_i (idx_q),
    .wdata_i (stats_new),
    .raddr_i (stats_raddr),
    .rdata_o (stats_rdata)
  );

  assign out_free   = !out_valid_q || out_ready_i;
  assign match      = cmp_valid_q && (addr_rdata == cur_q.addr);
  assign scan_end   = (rd_ptr_q == fill_q);
  assign table_full = (fill_q == CW'(TABLE_ENTRIES));

  always_comb begin
    stats_base       = stats_rdata;
    if (!hit_q) begin
      stats_base.last  = '0;
      stats_base.min   = rtts_pkg::RTT_CEIL;
      stats_base.max   = rtts_pkg::RTT_FLOOR;
      stats_base.count = '0;
    end
    stats_new.last  = cur_q.rtt;
    stats_new.min   = (cur_q.rtt < stats_base.min) ? cur_q.rtt : stats_base.min;
    stats_new.max   = (stats_base.max < cur_q.rtt) ? cur_q.rtt : stats_base.max;
    stats_new.count = stats_base.count + 32'd1;
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      rtts_pkg::BS_IDLE: begin
        if (q_valid_i) begin
          state_d = q_item_i.reserved ? rtts_pkg::BS_DROP : rtts_pkg::BS_SCAN;
        end
      end
      rtts_pkg::BS_SCAN: begin
        if (match) begin
          state_d = rtts_pkg::BS_UPD;
        end else if (scan_end) begin
          state_d = table_full ? rtts_pkg::BS_DROP : rtts_pkg::BS_UPD;
        end
      end
      rtts_pkg::BS_UPD, rtts_pkg::BS_DROP: begin
        if (out_free) begin
          state_d = rtts_pkg::BS_IDLE;
        end
      end
      default: state_d = rtts_pkg::BS_IDLE;
    endcase
  end

  always_comb begin
    q_ready_o   = 1'b0;
    cur_d       = cur_q;
    fill_d      = fill_q;
    rd_ptr_d    = rd_ptr_q;
    cmp_idx_d   = cmp_idx_q;
    cmp_valid_d = cmp_valid_q;
    idx_d       = idx_q;
    hit_d       = hit_q;
    addr_we     = 1'b0;
    stats_we    = 1'b0;
    stats_raddr = idx_q;
    out_valid_d = out_valid_q && !out_ready_i;
    status_d    = status_q;
    index_d     = index_q;
    res_d       = res_q;
    in_use_d    = in_use_q;
    unique case (state_q)
      rtts_pkg::BS_IDLE: begin
        q_ready_o = 1'b1;
        if (q_valid_i) begin
          cur_d       = q_item_i;
          rd_ptr_d    = '0;
          cmp_valid_d = 1'b0;
        end
      end
      rtts_pkg::BS_SCAN: begin
        stats_raddr = cmp_idx_q;
        if (match) begin
          hit_d       = 1'b1;
          idx_d       = cmp_idx_q;
          cmp_valid_d = 1'b0;
        end else if (!scan_end) begin
          cmp_valid_d = 1'b1;
          cmp_idx_d   = rd_ptr_q[IW-1:0];
          rd_ptr_d    = rd_ptr_q + 1'b1;
        end else begin
          hit_d       = 1'b0;
          idx_d       = fill_q[IW-1:0];
          cmp_valid_d = 1'b0;
        end
      end
      rtts_pkg::BS_UPD: begin
        if (out_free) begin
          stats_we    = 1'b1;
          addr_we     = !hit_q;
          fill_d      = hit_q ? fill_q : fill_q + 1'b1;
          out_valid_d = 1'b1;
          status_d    = hit_q ? rtts_pkg::STAT_UPDATED : rtts_pkg::STAT_NEW;
          index_d     = 7'(idx_q);
          res_d       = stats_new;
          in_use_d    = hit_q ? 8'(fill_q) : 8'(fill_q + 1'b1);
        end
      end
      rtts_pkg::BS_DROP: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          status_d    = rtts_pkg::STAT_DROPPED;
          index_d     = '0;
          res_d       = '0;
          in_use_d    = 8'(fill_q);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= rtts_pkg::BS_IDLE;
      fill_q      <= '0;
      rd_ptr_q    <= '0;
      cmp_valid_q <= 1'b0;
      hit_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      fill_q      <= fill_d;
      rd_ptr_q    <= rd_ptr_d;
      cmp_valid_q <= cmp_valid_d;
      hit_q       <= hit_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q     <= cur_d;
    cmp_idx_q <= cmp_idx_d;
    idx_q     <= idx_d;
    status_q  <= status_d;
    index_q   <= index_d;
    res_q     <= res_d;
    in_use_q  <= in_use_d;
  end

  assign out_valid_o      = out_valid_q;
  assign status_o         = status_q;
  assign entry_index_o    = index_q;
  assign last_rtt_o       = res_q.last;
  assign min_rtt_o        = res_q.min;
  assign max_rtt_o        = res_q.max;
  assign sample_count_o   = res_q.count;
  assign entries_in_use_o = in_use_q;

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= CW'(TABLE_ENTRIES))
    else $error("fill level beyond table size");

  a_scan_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == rtts_pkg::BS_SCAN) |-> (rd_ptr_q <= fill_q))
    else $error("scan pointer passed fill level");

  a_hit_in_use: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == rtts_pkg::BS_UPD && hit_q) |-> (CW'(idx_q) < fill_q))
    else $error("hit on an unoccupied entry");

  a_claim_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == rtts_pkg::BS_UPD && !hit_q) |-> !table_full)
    else $error("claim attempted on a full table");

endmodule

`default_nettype wire
